### sv/ddet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Difference edge detector package
// Shared types and constants for the 3x3 difference edge detector.
// ----------------------------------------------------------------------------
package ddet_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W   = 8;
  localparam int FW_W    = 12;
  localparam int FH_W    = 13;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = 13;
  localparam int WCMP_W  = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
  localparam int CFG_DATA_W = (FW_W > FH_W) ? FW_W : FH_W;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

  localparam int OUT_FIFO_DEPTH = 4;
  localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
  localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             pad;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_res;
    logic             end_of_frame;
  } edge_out_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } item_ctl_t;

endpackage : ddet_pkg
`default_nettype wire

### sv/ddet_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data; a read of the
// entry being written returns the old contents.
// ----------------------------------------------------------------------------
module ddet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : ddet_ram
`default_nettype wire

### sv/ddet_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that decouples the pipeline from a stalling receiver.
// ----------------------------------------------------------------------------
module ddet_out_fifo
  import ddet_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire edge_out_t            push_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      edge_out_t            out_data,
  output      logic [OUT_CNT_W-1:0] count
);

  edge_out_t            entries [OUT_FIFO_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic                 pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + OUT_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - OUT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < OUT_CNT_W'(OUT_FIFO_DEPTH))
    else $error("result queue overflow");
`endif

endmodule : ddet_out_fifo
`default_nettype wire

### sv/difference_edge_detect_3x3_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// 3x3 difference edge detector
// Line buffers and a 3x3 window give the largest opposite-neighbour
// difference of each interior pixel.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel in raster order, followed by frame_width+1
// pad items that flush the frame. Each item after the first frame_width+1 of
// a frame yields one result on the out channel; border pixels give 0 and the
// last result of a frame carries end_of_frame.
// One item is accepted per clock while in_ready is high. The upper and middle
// lines share one RAM entry per column, read when the item is accepted and
// written back in the next cycle; a read that meets the write of the same
// column is forwarded. An accepted item is registered into the s1 stage,
// where RAM data arrives, then into s2, whose window result goes to the queue.
// A four-entry result queue lets the receiver stall: in_ready falls while the
// items in the queue and in the two pipeline stages number four or more, so
// that no accepted item can overflow the queue.
// Reset clears the position counters, the window and the queue, and loads
// frame_width 640 and frame_height 480. The RAM is not cleared; its entries
// are written before any interior result uses them.
// Registers are to be written over cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module difference_edge_detect_3x3_top
  import ddet_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire pixel_in_t             in_data,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      edge_out_t             out_data,
  input  wire logic                  cfg_we,
  input  wire cfg_index_t            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [WCMP_W-1:0] w_eff;
  logic [FH_W-1:0]   h_eff;

  logic [COL_W-1:0]  column;
  logic [ROW_W-1:0]  row;
  logic [WCMP_W-1:0] column_ext;
  logic              accept;
  logic              final_item;
  logic              row_wrap;
  item_ctl_t         in_ctl;

  logic                 s1_valid;
  logic [COL_W-1:0]     s1_addr;
  logic [PIX_W-1:0]     s1_v;
  logic                 s1_fwd;
  item_ctl_t            s1_ctl;
  logic [2*PIX_W-1:0]   rd_data;
  logic [PIX_W-1:0]     top_pix;
  logic [PIX_W-1:0]     mid_pix;
  logic [PIX_W-1:0]     fwd_mid;
  logic [PIX_W-1:0]     fwd_v;
  logic [PIX_W-1:0]     win [3][3];

  logic                 s2_valid;
  item_ctl_t            s2_ctl;
  logic [PIX_W-1:0]     edge_max;
  edge_out_t            push_data;
  logic                 push;
  logic [OUT_CNT_W-1:0] fifo_count;
  logic [OUT_CNT_W:0]   in_flight;

  function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < FW_W'(3)) begin
      w_eff = WCMP_W'(3);
    end else if (WCMP_W'(frame_width) > WCMP_W'(MAX_WIDTH)) begin
      w_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      w_eff = WCMP_W'(frame_width);
    end
    if (frame_height < FH_W'(3)) begin
      h_eff = FH_W'(3);
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      h_eff = FH_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign in_flight  = (OUT_CNT_W+1)'(fifo_count) + (OUT_CNT_W+1)'(s1_valid)
                    + (OUT_CNT_W+1)'(s2_valid);
  assign in_ready   = in_flight < (OUT_CNT_W+1)'(OUT_FIFO_DEPTH);
  assign accept     = in_valid && in_ready;

  assign column_ext = WCMP_W'(column);
  assign final_item = row > ROW_W'(h_eff);
  assign row_wrap   = (column_ext + WCMP_W'(1)) >= w_eff;

  always_comb begin
    in_ctl.last     = final_item;
    in_ctl.emit     = final_item ||
                      !((row == '0) || ((row == ROW_W'(1)) && (column == '0)));
    in_ctl.interior = !final_item && (column_ext >= WCMP_W'(2)) &&
                      (column_ext <= w_eff - WCMP_W'(1)) &&
                      (row >= ROW_W'(2)) && (row <= ROW_W'(h_eff) - ROW_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (accept) begin
      if (final_item) begin
        column <= '0;
        row    <= '0;
      end else if (row_wrap) begin
        column <= '0;
        row    <= row + ROW_W'(1);
      end else begin
        column <= column + COL_W'(1);
      end
    end
  end

  ddet_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata ({mid_pix, s1_v}),
    .re    (accept),
    .raddr (column),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= column;
      s1_v    <= in_data.pad ? '0 : in_data.pixel;
      s1_fwd  <= s1_valid && (s1_addr == column);
      s1_ctl  <= in_ctl;
    end
    if (s1_valid) begin
      fwd_mid <= mid_pix;
      fwd_v   <= s1_v;
    end
    s2_ctl <= s1_ctl;
  end

  assign top_pix = s1_fwd ? fwd_mid : rd_data[2*PIX_W-1:PIX_W];
  assign mid_pix = s1_fwd ? fwd_v   : rd_data[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= top_pix;
      win[1][2] <= mid_pix;
      win[2][2] <= s1_v;
    end
  end

  always_comb begin
    logic [PIX_W-1:0] d0;
    logic [PIX_W-1:0] d1;
    logic [PIX_W-1:0] d2;
    logic [PIX_W-1:0] d3;
    logic [PIX_W-1:0] m0;
    logic [PIX_W-1:0] m1;
    d0 = absdiff(win[0][0], win[2][2]);
    d1 = absdiff(win[0][2], win[2][0]);
    d2 = absdiff(win[0][1], win[2][1]);
    d3 = absdiff(win[1][0], win[1][2]);
    m0 = (d1 > d0) ? d1 : d0;
    m1 = (d3 > d2) ? d3 : d2;
    edge_max = (m1 > m0) ? m1 : m0;
  end

  assign push                   = s2_valid && s2_ctl.emit;
  assign push_data.edge_res     = s2_ctl.interior ? edge_max : '0;
  assign push_data.end_of_frame = s2_ctl.last;

  ddet_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (fifo_count)
  );

`ifndef SYNTHESIS
  a_final_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && final_item |=> (column == '0) && (row == '0))
    else $error("position not restarted after the last item of a frame");

  a_fwd_same_column: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_fwd |-> $past(s1_valid) && ($past(s1_addr) == s1_addr))
    else $error("forwarding without a write to the same column");

  a_last_is_border: assert property (@(posedge clk) disable iff (rst)
    push && push_data.end_of_frame |-> push_data.edge_res == '0)
    else $error("end of frame item with a non-zero result");

  a_pipe_advances: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid ##1 s2_valid)
    else $error("accepted item lost in the pipeline");
`endif

endmodule : difference_edge_detect_3x3_top
`default_nettype wire

### dv/difference_edge_detect_3x3_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3x3 difference edge detector testbench
// Streams whole frames of pixels and flush items through the block, with
// random idling on both channels, and compares every result with typed values
// or with a bit-accurate frame model kept inside the bench.
// ----------------------------------------------------------------------------
module difference_edge_detect_3x3_top_tb;
  import ddet_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             pad;
    logic             typed;
    logic             has_res;
    logic [PIX_W-1:0] edge_v;
    logic             eof;
  } stim_row_t;

  // The first frame has typed results; the second relies on the model.
  localparam stim_row_t DIRECTED [26] = '{
    '{8'd255, 1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
    '{8'd128, 1'b0, 1'b1, 1'b1, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b1, 1'b1, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b1, 1'b1, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b1, 1'b1, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b1, 1'b1, 8'd255, 1'b0},
    '{8'd255, 1'b1, 1'b1, 1'b1, 8'd0,   1'b0},
    '{8'd255, 1'b1, 1'b1, 1'b1, 8'd0,   1'b0},
    '{8'd255, 1'b1, 1'b1, 1'b1, 8'd0,   1'b0},
    '{8'd255, 1'b1, 1'b1, 1'b1, 8'd0,   1'b1},
    '{8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd255, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd90,  1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd7,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd30,  1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd255, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd77,  1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd200, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd13,  1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd255, 1'b1, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd255, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0}
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pixel_in_t             in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  edge_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  cfg_index_t            cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned items_sent    = 0;
  int          fail_count    = 0;
  edge_out_t   pending_edges[$];

  logic [PIX_W-1:0] row_above  [MAX_WIDTH] = '{default: '0};
  logic [PIX_W-1:0] row_centre [MAX_WIDTH] = '{default: '0};
  logic [PIX_W-1:0] nbhd [3][3]            = '{default: '{default: '0}};
  int unsigned      col_pos    = 0;
  int unsigned      row_pos    = 0;
  logic [FW_W-1:0]  width_reg  = FRAME_WIDTH_RST;
  logic [FH_W-1:0]  height_reg = FRAME_HEIGHT_RST;

  difference_edge_detect_3x3_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned span_w();
    int unsigned v;
    v = 32'(width_reg);
    if (v < 3) v = 3;
    if (v > MAX_WIDTH) v = MAX_WIDTH;
    return v;
  endfunction

  function automatic int unsigned span_h();
    int unsigned v;
    v = 32'(height_reg);
    if (v < 3) v = 3;
    if (v > MAX_HEIGHT) v = MAX_HEIGHT;
    return v;
  endfunction

  function automatic int unsigned pix_dist(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // Advances the frame model by one item; returns 1 when the item yields a result.
  function automatic logic edge_predict(input pixel_in_t item, output edge_out_t res);
    int unsigned      w, h, c, r, ci, e, d;
    logic [PIX_W-1:0] v, up, mid;
    w  = span_w();
    h  = span_h();
    c  = col_pos;
    r  = row_pos;
    v  = item.pad ? '0 : item.pixel;
    ci = c % MAX_WIDTH;
    up = row_above[ci];
    mid = row_centre[ci];
    row_above[ci]  = mid;
    row_centre[ci] = v;
    for (int i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = up;
    nbhd[1][2] = mid;
    nbhd[2][2] = v;
    res = '0;
    if (r > h) begin
      res.end_of_frame = 1'b1;
      col_pos = 0;
      row_pos = 0;
      return 1'b1;
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    if (r == 0 || (r == 1 && c == 0)) return 1'b0;
    e = 0;
    if (c >= 2 && c <= w - 1 && r >= 2 && r <= h - 1) begin
      e = pix_dist(nbhd[0][0], nbhd[2][2]);
      d = pix_dist(nbhd[0][2], nbhd[2][0]);
      if (d > e) e = d;
      d = pix_dist(nbhd[0][1], nbhd[2][1]);
      if (d > e) e = d;
      d = pix_dist(nbhd[1][0], nbhd[1][2]);
      if (d > e) e = d;
    end
    res.edge_res = e[PIX_W-1:0];
    return 1'b1;
  endfunction

  task automatic send_item(input pixel_in_t item, input logic typed, input logic typed_has,
                           input edge_out_t typed_res, output logic last);
    int unsigned gap;
    logic        has;
    edge_out_t   res;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    has = edge_predict(item, res);
    if (typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) pending_edges.push_back(res);
    last = has && res.end_of_frame;
    items_sent++;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frame_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    width_reg = w[FW_W-1:0];
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    height_reg = h[FH_W-1:0];
    cfg_we <= 1'b0;
  endtask

  // One frame of random pixels; the size may be rewritten after change_at items.
  task automatic run_frame(input int unsigned noise_pct, input int change_at,
                           input logic [CFG_DATA_W-1:0] new_w,
                           input logic [CFG_DATA_W-1:0] new_h);
    pixel_in_t item;
    logic      last;
    int        n;
    last = 1'b0;
    n    = 0;
    while (!last) begin
      if (n == change_at) begin
        wait_quiet();
        set_frame_size(new_w, new_h);
      end else if ($urandom_range(299) == 0) begin
        wait_quiet();
      end
      item.pad = (row_pos >= span_h());
      case ($urandom_range(5))
        0:       item.pixel = '0;
        1:       item.pixel = '1;
        default: item.pixel = PIX_W'($urandom_range(255));
      endcase
      if ($urandom_range(99) < noise_pct) item.pad = ~item.pad;
      send_item(item, 1'b0, 1'b0, '0, last);
      n++;
    end
  endtask

  task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                              input int unsigned target);
    int unsigned start, w, h;
    int          change;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    start         = items_sent;
    while (items_sent - start < target) begin
      wait_quiet();
      w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(12, 3);
      h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(7, 3);
      set_frame_size(CFG_DATA_W'(w), CFG_DATA_W'(h));
      change = ($urandom_range(4) == 0) ? int'($urandom_range(40, 5)) : -1;
      run_frame(5, change, CFG_DATA_W'(w), CFG_DATA_W'($urandom_range(8)));
    end
  endtask

  always @(posedge clk) begin
    edge_out_t want;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (pending_edges.size() == 0) begin
        fail_count++;
        if (fail_count < 100)
          $error("unexpected item: edge_res %0d end_of_frame %0d",
                 out_data.edge_res, out_data.end_of_frame);
      end else begin
        want = pending_edges.pop_front();
        if (out_data.edge_res !== want.edge_res) begin
          fail_count++;
          if (fail_count < 100)
            $error("edge_res: expected %0d, actual %0d", want.edge_res, out_data.edge_res);
        end
        if (out_data.end_of_frame !== want.end_of_frame) begin
          fail_count++;
          if (fail_count < 100)
            $error("end_of_frame: expected %0d, actual %0d",
                   want.end_of_frame, out_data.end_of_frame);
        end
      end
    end
  end

  initial begin
    logic last;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_frame_size(3, 3);
    send_idle_pct = 16;
    stall_pct     = 85;
    foreach (DIRECTED[k]) begin
      send_item('{pixel: DIRECTED[k].pix, pad: DIRECTED[k].pad}, DIRECTED[k].typed,
                DIRECTED[k].has_res,
                '{edge_res: DIRECTED[k].edge_v, end_of_frame: DIRECTED[k].eof}, last);
    end

    random_phase(16, 85, 150);
    // A width written with the top data bit set keeps only its low twelve bits.
    wait_quiet();
    set_frame_size(13'h1005, 4);
    run_frame(5, -1, '0, '0);
    random_phase(85, 16, 150);
    random_phase(0, 0, 120);

    // A height below the minimum is used as three.
    wait_quiet();
    set_frame_size(20, 0);
    run_frame(2, -1, '0, '0);
    // Every column in use has been written, so the width may change inside a frame.
    wait_quiet();
    set_frame_size(20, 5);
    run_frame(2, 50, 7, 5);
    wait_quiet();
    set_frame_size(6, 6);
    run_frame(2, 15, 18, 6);

    wait_quiet();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("difference_edge_detect_3x3_top test passed");
    end else begin
      $display("difference_edge_detect_3x3_top test failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("difference_edge_detect_3x3_top test failed");
    $finish;
  end

endmodule

### filelist.f
sv/ddet_pkg.sv
sv/ddet_ram.sv
sv/ddet_out_fifo.sv
sv/difference_edge_detect_3x3_top.sv
dv/difference_edge_detect_3x3_top_tb.sv
